// File: hw/rtl/vbvp_pkg.sv
`timescale 1ns / 1ps
package vbvp_pkg;

  // Field widths
  localparam int Q_W        = 32;
  localparam int WIDE_W     = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT   = 1'b1;

  // Alignment codes
  localparam logic [3:0] ALIGN_UNKNOWN   = 4'd0;
  localparam logic [3:0] ALIGN_NONE      = 4'd1;
  localparam logic [3:0] ALIGN_XMIN_YMIN = 4'd2;
  localparam logic [3:0] ALIGN_XMID_YMIN = 4'd3;
  localparam logic [3:0] ALIGN_XMAX_YMIN = 4'd4;
  localparam logic [3:0] ALIGN_XMIN_YMID = 4'd5;
  localparam logic [3:0] ALIGN_XMID_YMID = 4'd6;
  localparam logic [3:0] ALIGN_XMAX_YMID = 4'd7;
  localparam logic [3:0] ALIGN_XMIN_YMAX = 4'd8;
  localparam logic [3:0] ALIGN_XMID_YMAX = 4'd9;
  localparam logic [3:0] ALIGN_XMAX_YMAX = 4'd10;

  // Fit codes
  localparam logic [1:0] FIT_UNKNOWN = 2'd0;
  localparam logic [1:0] FIT_MEET    = 2'd1;
  localparam logic [1:0] FIT_SLICE   = 2'd2;

  // Saturation bounds of a Q value held in a wide word
  localparam logic signed [WIDE_W-1:0] Q_MAX =
    $signed({{(WIDE_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] Q_MIN = ~Q_MAX;

  // Where the leftover space goes on the free axis
  typedef enum logic [1:0] {
    PLACE_MIN = 2'd0,
    PLACE_MID = 2'd1,
    PLACE_MAX = 2'd2
  } place_t;

  typedef struct packed {
    place_t kx;
    place_t ky;
  } place_pair_t;

  typedef struct packed {
    logic signed [Q_W-1:0] lx;
    logic signed [Q_W-1:0] ly;
    logic signed [Q_W-1:0] lw;
    logic signed [Q_W-1:0] lh;
    logic signed [Q_W-1:0] pw;
    logic signed [Q_W-1:0] ph;
  } box_t;

  // Sideband that travels alongside the dividers
  typedef struct packed {
    logic                  ident;
    logic                  none;
    logic                  use_h;
    logic signed [Q_W-1:0] lx;
    logic signed [Q_W-1:0] ly;
    logic signed [Q_W-1:0] len;
    place_t                k;
  } side_t;

  typedef struct packed {
    logic           sat;
    logic [Q_W-1:0] val;
  } clamp_t;

  function automatic place_pair_t decode_place(input logic [3:0] align);
    place_pair_t p;
    case (align)
      ALIGN_XMIN_YMIN: p = '{PLACE_MIN, PLACE_MIN};
      ALIGN_XMID_YMIN: p = '{PLACE_MID, PLACE_MIN};
      ALIGN_XMAX_YMIN: p = '{PLACE_MAX, PLACE_MIN};
      ALIGN_XMIN_YMID: p = '{PLACE_MIN, PLACE_MID};
      ALIGN_XMID_YMID: p = '{PLACE_MID, PLACE_MID};
      ALIGN_XMAX_YMID: p = '{PLACE_MAX, PLACE_MID};
      ALIGN_XMIN_YMAX: p = '{PLACE_MIN, PLACE_MAX};
      ALIGN_XMID_YMAX: p = '{PLACE_MID, PLACE_MAX};
      ALIGN_XMAX_YMAX: p = '{PLACE_MAX, PLACE_MAX};
      default:         p = '{PLACE_MIN, PLACE_MIN};
    endcase
    return p;
  endfunction

  function automatic clamp_t clamp_q(input logic signed [WIDE_W-1:0] v);
    clamp_t c;
    if (v > Q_MAX) begin
      c.sat = 1'b1;
      c.val = Q_MAX[Q_W-1:0];
    end else if (v < Q_MIN) begin
      c.sat = 1'b1;
      c.val = Q_MIN[Q_W-1:0];
    end else begin
      c.sat = 1'b0;
      c.val = v[Q_W-1:0];
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/vbvp_in_if.sv
`timescale 1ns / 1ps
interface vbvp_in_if;
  import vbvp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] box_x;
  logic signed [Q_W-1:0] box_y;
  logic signed [Q_W-1:0] box_width;
  logic signed [Q_W-1:0] box_height;
  logic signed [Q_W-1:0] view_width;
  logic signed [Q_W-1:0] view_height;

  modport source (
    output valid, box_x, box_y, box_width, box_height, view_width, view_height,
    input  ready
  );

  modport sink (
    input  valid, box_x, box_y, box_width, box_height, view_width, view_height,
    output ready
  );
endinterface

// File: hw/rtl/vbvp_out_if.sv
`timescale 1ns / 1ps
interface vbvp_out_if;
  import vbvp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] scale_x;
  logic signed [Q_W-1:0] scale_y;
  logic signed [Q_W-1:0] offset_x;
  logic signed [Q_W-1:0] offset_y;
  logic                  identity_flag;
  logic                  saturated;

  modport source (
    output valid, scale_x, scale_y, offset_x, offset_y, identity_flag, saturated,
    input  ready
  );

  modport sink (
    input  valid, scale_x, scale_y, offset_x, offset_y, identity_flag, saturated,
    output ready
  );
endinterface

// File: hw/rtl/vbvp_div.sv
`timescale 1ns / 1ps
// Pipelined signed divider, truncating toward zero: one quotient bit per stage.
module vbvp_div (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [vbvp_pkg::WIDE_W-1:0]    dividend,
  input  logic signed [vbvp_pkg::Q_W-1:0]       divisor,
  output logic signed [vbvp_pkg::WIDE_W-1:0]    quotient
);
  import vbvp_pkg::*;

  logic [Q_W-1:0]    rem_r [WIDE_W+1];
  logic [WIDE_W-1:0] dq_r  [WIDE_W+1];
  logic [Q_W-1:0]    dvs_r [WIDE_W+1];
  logic              neg_r [WIDE_W+1];
  logic signed [WIDE_W-1:0] q_r;

  logic [WIDE_W-1:0] mag_a;
  logic [Q_W-1:0]    mag_b;

  // Magnitudes and result sign
  always_comb begin
    mag_a = dividend[WIDE_W-1] ? WIDE_W'(-dividend) : WIDE_W'(dividend);
    mag_b = divisor[Q_W-1] ? Q_W'(-divisor) : Q_W'(divisor);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      dq_r[0]  <= mag_a;
      dvs_r[0] <= mag_b;
      neg_r[0] <= dividend[WIDE_W-1] ^ divisor[Q_W-1];
    end
  end

  // Restoring steps: shift in the next dividend bit, trial subtract
  for (genvar i = 0; i < WIDE_W; i++) begin : g_step
    logic [Q_W:0] trial;
    logic [Q_W:0] diff;
    logic         ge;

    always_comb begin
      trial = {rem_r[i], dq_r[i][WIDE_W-1]};
      diff  = trial - {1'b0, dvs_r[i]};
      ge    = !diff[Q_W];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
        dq_r[i+1]  <= {dq_r[i][WIDE_W-2:0], ge};
        dvs_r[i+1] <= dvs_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // Sign fix-up
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= neg_r[WIDE_W] ? -$signed(dq_r[WIDE_W]) : $signed(dq_r[WIDE_W]);
    end
  end

  assign quotient = q_r;

endmodule

// File: hw/rtl/viewbox_to_viewport_transform.sv
`timescale 1ns / 1ps
// An input transfer passes through stages 1 to 3, the dividers, F1 to F3 and the output register.
// Throughput: one box per cycle while the output is not stalled; the two pipelined dividers set the depth.
// The whole pipeline advances together and holds while the output register is
// full and not taken. Reset (rst_n low, synchronous) clears all valid bits and
// sets align_r to xMidYMid and fit_r to meet.
module viewbox_to_viewport_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  vbvp_in_if.sink                            in_ch,
  vbvp_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [vbvp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vbvp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import vbvp_pkg::*;

  localparam int DIV_LAT = WIDE_W + 2;
  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

  logic en;

  // Configuration registers
  logic [3:0] align_r;
  logic [1:0] fit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= ALIGN_XMID_YMID;
      fit_r   <= FIT_MEET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALIGN: align_r <= cfg_wdata;
        CFG_FIT:   fit_r   <= cfg_wdata[1:0];
        default:   ;
      endcase
    end
  end

  // Stage 1: capture, degenerate check, cross products
  logic                     s1_v_r;
  box_t                     s1_box_r;
  logic signed [WIDE_W-1:0] s1_cl_r, s1_cp_r;
  logic                     s1_ident_r, s1_none_r;
  place_pair_t              s1_pl_r;
  logic                     s1_ident_nxt;
  logic signed [WIDE_W-1:0] s1_cl_nxt, s1_cp_nxt;

  always_comb begin
    s1_ident_nxt = (in_ch.box_width == '0) || (in_ch.box_height == '0) ||
                   (in_ch.view_width == '0) || (in_ch.view_height == '0) ||
                   !(align_r inside {[ALIGN_NONE:ALIGN_XMAX_YMAX]});
    s1_cl_nxt = in_ch.box_width * in_ch.view_height;
    s1_cp_nxt = in_ch.view_width * in_ch.box_height;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_box_r   <= '{in_ch.box_x, in_ch.box_y, in_ch.box_width, in_ch.box_height,
                      in_ch.view_width, in_ch.view_height};
      s1_cl_r    <= s1_cl_nxt;
      s1_cp_r    <= s1_cp_nxt;
      s1_ident_r <= s1_ident_nxt;
      s1_none_r  <= (align_r == ALIGN_NONE);
      s1_pl_r    <= decode_place(align_r);
    end
  end

  // Stage 2: aspect ratio comparison and meet/slice choice
  logic        s2_v_r;
  box_t        s2_box_r;
  logic        s2_ident_r, s2_none_r, s2_use_h_r;
  place_pair_t s2_pl_r;
  logic        denom_pos, less, use_h_nxt;

  always_comb begin
    denom_pos = ($signed(s1_box_r.lh) > 0) == ($signed(s1_box_r.ph) > 0);
    less      = denom_pos ? (s1_cl_r < s1_cp_r) : (s1_cl_r > s1_cp_r);
    use_h_nxt = (less && fit_r == FIT_MEET) || (!less && fit_r == FIT_SLICE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_box_r   <= s1_box_r;
      s2_ident_r <= s1_ident_r;
      s2_none_r  <= s1_none_r;
      s2_use_h_r <= use_h_nxt;
      s2_pl_r    <= s1_pl_r;
    end
  end

  // Stage 3: operand selection and fitted-length product
  logic                     s3_v_r;
  side_t                    s3_sb_r;
  logic signed [WIDE_W-1:0] s3_da_r, s3_db_r;
  logic signed [Q_W-1:0]    s3_ba_r, s3_bb_r;
  logic signed [Q_W-1:0]    m1, m2;
  logic signed [WIDE_W-1:0] prod, pw_sh, ph_sh, da_nxt, db_nxt;
  logic signed [Q_W-1:0]    ba_nxt, bb_nxt;
  logic                     hsel;
  side_t                    sb_nxt;

  always_comb begin
    hsel   = s2_use_h_r && !s2_none_r;
    m1     = s2_use_h_r ? $signed(s2_box_r.pw) : $signed(s2_box_r.ph);
    m2     = s2_use_h_r ? $signed(s2_box_r.lh) : $signed(s2_box_r.lw);
    prod   = m1 * m2;
    pw_sh  = WIDE_W'($signed(s2_box_r.pw)) <<< FRAC_BITS;
    ph_sh  = WIDE_W'($signed(s2_box_r.ph)) <<< FRAC_BITS;
    da_nxt = hsel ? ph_sh : pw_sh;
    ba_nxt = hsel ? $signed(s2_box_r.lh) : $signed(s2_box_r.lw);
    db_nxt = s2_none_r ? ph_sh : prod;
    bb_nxt = s2_none_r ? $signed(s2_box_r.lh)
                       : (s2_use_h_r ? $signed(s2_box_r.ph) : $signed(s2_box_r.pw));
    sb_nxt.ident = s2_ident_r;
    sb_nxt.none  = s2_none_r;
    sb_nxt.use_h = s2_use_h_r;
    sb_nxt.lx    = s2_box_r.lx;
    sb_nxt.ly    = s2_box_r.ly;
    sb_nxt.len   = s2_use_h_r ? s2_box_r.lw : s2_box_r.lh;
    sb_nxt.k     = s2_use_h_r ? s2_pl_r.kx : s2_pl_r.ky;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sb_r <= sb_nxt;
      s3_da_r <= da_nxt;
      s3_db_r <= db_nxt;
      s3_ba_r <= ba_nxt;
      s3_bb_r <= bb_nxt;
    end
  end

  // Dividers: scale on A, second scale or fitted length on B
  logic signed [WIDE_W-1:0] qa, qb;

  vbvp_div u_div_a (
    .clk      (clk),
    .en       (en),
    .dividend (s3_da_r),
    .divisor  (s3_ba_r),
    .quotient (qa)
  );

  vbvp_div u_div_b (
    .clk      (clk),
    .en       (en),
    .dividend (s3_db_r),
    .divisor  (s3_bb_r),
    .quotient (qb)
  );

  // Sideband delay line matched to the dividers
  side_t              sb_r [DIV_LAT];
  logic [DIV_LAT-1:0] dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[DIV_LAT-2:0], s3_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= s3_sb_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // F1: scales and slack on the free axis
  logic                     f1_v_r;
  side_t                    f1_sb_r;
  logic signed [WIDE_W-1:0] f1_sx_r, f1_sy_r, f1_slack_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= dv_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_sb_r    <= sb_r[DIV_LAT-1];
      f1_sx_r    <= qa;
      f1_sy_r    <= sb_r[DIV_LAT-1].none ? qb : qa;
      f1_slack_r <= WIDE_W'($signed(sb_r[DIV_LAT-1].len)) - qb;
    end
  end

  // F2: min / mid / max adjustment
  logic                     f2_v_r;
  side_t                    f2_sb_r;
  logic signed [WIDE_W-1:0] f2_sx_r, f2_sy_r, f2_adj_r;
  logic signed [WIDE_W-1:0] adj_nxt;

  always_comb begin
    case (f1_sb_r.k)
      PLACE_MID: adj_nxt = f1_slack_r / 2;
      PLACE_MAX: adj_nxt = f1_slack_r;
      default:   adj_nxt = '0;
    endcase
    if (f1_sb_r.none) begin
      adj_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (en) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_sb_r  <= f1_sb_r;
      f2_sx_r  <= f1_sx_r;
      f2_sy_r  <= f1_sy_r;
      f2_adj_r <= adj_nxt;
    end
  end

  // F3: offsets
  logic                     f3_v_r;
  logic                     f3_ident_r;
  logic signed [WIDE_W-1:0] f3_sx_r, f3_sy_r, f3_ox_r, f3_oy_r;
  logic signed [WIDE_W-1:0] adj_x, adj_y;

  always_comb begin
    adj_x = f2_sb_r.use_h ? f2_adj_r : '0;
    adj_y = f2_sb_r.use_h ? '0 : f2_adj_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_v_r <= 1'b0;
    end else if (en) begin
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_ident_r <= f2_sb_r.ident;
      f3_sx_r    <= f2_sx_r;
      f3_sy_r    <= f2_sy_r;
      f3_ox_r    <= -WIDE_W'($signed(f2_sb_r.lx)) - adj_x;
      f3_oy_r    <= -WIDE_W'($signed(f2_sb_r.ly)) - adj_y;
    end
  end

  // Output register: saturation and identity override
  logic           out_v_r;
  logic [Q_W-1:0] out_sx_r, out_sy_r, out_ox_r, out_oy_r;
  logic           out_id_r, out_sat_r;
  clamp_t         c_sx, c_sy, c_ox, c_oy;

  always_comb begin
    c_sx = clamp_q(f3_sx_r);
    c_sy = clamp_q(f3_sy_r);
    c_ox = clamp_q(f3_ox_r);
    c_oy = clamp_q(f3_oy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= f3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f3_ident_r) begin
        out_sx_r  <= ONE_Q;
        out_sy_r  <= ONE_Q;
        out_ox_r  <= '0;
        out_oy_r  <= '0;
        out_id_r  <= 1'b1;
        out_sat_r <= 1'b0;
      end else begin
        out_sx_r  <= c_sx.val;
        out_sy_r  <= c_sy.val;
        out_ox_r  <= c_ox.val;
        out_oy_r  <= c_oy.val;
        out_id_r  <= 1'b0;
        out_sat_r <= c_sx.sat | c_sy.sat | c_ox.sat | c_oy.sat;
      end
    end
  end

  // Global advance: move whenever the output register is free or being taken
  assign en = !out_v_r || out_ch.ready;

  assign in_ch.ready          = en;
  assign out_ch.valid         = out_v_r;
  assign out_ch.scale_x       = out_sx_r;
  assign out_ch.scale_y       = out_sy_r;
  assign out_ch.offset_x      = out_ox_r;
  assign out_ch.offset_y      = out_oy_r;
  assign out_ch.identity_flag = out_id_r;
  assign out_ch.saturated     = out_sat_r;

endmodule

// File: hw/rtl/vbvp_checker.sv
`timescale 1ns / 1ps
module vbvp_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [vbvp_pkg::Q_W-1:0]           scale_x,
  input logic [vbvp_pkg::Q_W-1:0]           scale_y,
  input logic [vbvp_pkg::Q_W-1:0]           offset_x,
  input logic [vbvp_pkg::Q_W-1:0]           offset_y,
  input logic                               identity_flag,
  input logic                               saturated
);
  import vbvp_pkg::*;

  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(scale_x) && $stable(scale_y) &&
      $stable(offset_x) && $stable(offset_y) && $stable(identity_flag))
    else $error("stalled result changed");

  // A stalled output freezes the pipeline, so no new box enters
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // Identity results are exact and never flagged as clamped
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && identity_flag |-> scale_x == ONE_Q && scale_y == ONE_Q &&
      offset_x == '0 && offset_y == '0 && !saturated)
    else $error("identity result malformed");

endmodule

bind viewbox_to_viewport_transform vbvp_checker #(.FRAC_BITS(FRAC_BITS)) u_vbvp_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .scale_x       (out_ch.scale_x),
  .scale_y       (out_ch.scale_y),
  .offset_x      (out_ch.offset_x),
  .offset_y      (out_ch.offset_y),
  .identity_flag (out_ch.identity_flag),
  .saturated     (out_ch.saturated)
);
